/* src/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, off while reset is low.
`define GPM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property whose consequent is checked in the cycle after the antecedent.
`define GPM_ASSERT_NEXT(lbl, pre, post, msg) `GPM_ASSERT(lbl, (pre) |=> (post), msg)

`endif

/* src/gpm_pkg.sv */
// Package of the green pixel classifier: widths, register codes and pipeline types.
`timescale 1ns / 1ps

package gpm_pkg;

  localparam int CHANNEL_BITS = 8;
  localparam int CHAN_MAX     = (1 << CHANNEL_BITS) - 1;

  // Divider operand widths: numerators stay below 2^(2C+1), denominators are 2*value.
  localparam int NUM_W      = 2 * CHANNEL_BITS + 1;
  localparam int DEN_W      = CHANNEL_BITS + 1;
  localparam int Q_W        = CHANNEL_BITS;
  localparam int DIV_STAGES = Q_W;
  localparam int QI_W       = $clog2(Q_W);

  // Hue numerator arithmetic, signed, wide enough for 150*max + sector offset.
  localparam int HNUM_W     = 2 * CHANNEL_BITS + 2;
  localparam int EXG_W      = CHANNEL_BITS + 3;
  localparam int DIF_W      = CHANNEL_BITS + 1;

  localparam int HUE_SIXTH  = 30;
  localparam int HUE_HALF   = 180;

  typedef logic [CHANNEL_BITS-1:0] chan_t;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_EXG_LOW  = 3'd0,
    REG_EXG_HIGH = 3'd1,
    REG_HUE_LOW  = 3'd2,
    REG_HUE_HIGH = 3'd3,
    REG_SAT_LOW  = 3'd4,
    REG_SAT_HIGH = 3'd5,
    REG_VAL_LOW  = 3'd6,
    REG_VAL_HIGH = 3'd7
  } cfg_idx_e;

  localparam chan_t RST_EXG_LOW  = chan_t'(30);
  localparam chan_t RST_EXG_HIGH = chan_t'(250);
  localparam chan_t RST_HUE_LOW  = chan_t'(30);
  localparam chan_t RST_HUE_HIGH = chan_t'(90);
  localparam chan_t RST_SAT_LOW  = chan_t'(30);
  localparam chan_t RST_SAT_HIGH = chan_t'(255);
  localparam chan_t RST_VAL_LOW  = chan_t'(5);
  localparam chan_t RST_VAL_HIGH = chan_t'(200);

  // Hue sector: which channel holds the maximum.
  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_e;

  typedef struct packed {
    chan_t exg_low;
    chan_t exg_high;
    chan_t hue_low;
    chan_t hue_high;
    chan_t sat_low;
    chan_t sat_high;
    chan_t val_low;
    chan_t val_high;
  } gpm_cfg_t;

  // Values that ride alongside the divider.
  typedef struct packed {
    chan_t exg;
    chan_t mx;
    logic  grey;
  } gpm_side_t;

  // One lane of the restoring divider.
  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [Q_W-1:0]   quo;
  } div_lane_t;

  typedef struct packed {
    div_lane_t sat;
    div_lane_t hue;
    gpm_side_t side;
  } div_st_t;

endpackage

/* src/green_pixel_mask_classifier_top.sv */
// Top level of the green plant pixel classifier: excess green, HSV and range mask.
//
//   channel   dir   width  contents (lowest bit first)
//   s_axis    in    24     blue, green, red
//   m_axis    out   40     plant, excess_green, hue, saturation, brightness, zero pad
//   cfg       in    3+8    register index, register value; no read-back
//
// One beat per cycle in and out while the output is not stalled; registered steps in order:
// min/max and excess green, hue/saturation numerators, eight divider stages (one quotient
// bit each), and the range-test output register. Each stage holds on a stall and refills
// its bubbles, so input keeps flowing while a result waits, until the pipeline is full.
// Reset loads the register defaults and empties the pipeline.
`timescale 1ns / 1ps

module green_pixel_mask_classifier_top
  import gpm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // blue [7:0], green [15:8], red [23:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // plant [0], excess_green [8:1], hue [16:9],
                                     // saturation [24:17], brightness [32:25], zeros
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i
);

  gpm_cfg_t cfg_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.exg_low  <= RST_EXG_LOW;
      cfg_q.exg_high <= RST_EXG_HIGH;
      cfg_q.hue_low  <= RST_HUE_LOW;
      cfg_q.hue_high <= RST_HUE_HIGH;
      cfg_q.sat_low  <= RST_SAT_LOW;
      cfg_q.sat_high <= RST_SAT_HIGH;
      cfg_q.val_low  <= RST_VAL_LOW;
      cfg_q.val_high <= RST_VAL_HIGH;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_EXG_LOW:  cfg_q.exg_low  <= cfg_data_i;
        REG_EXG_HIGH: cfg_q.exg_high <= cfg_data_i;
        REG_HUE_LOW:  cfg_q.hue_low  <= cfg_data_i;
        REG_HUE_HIGH: cfg_q.hue_high <= cfg_data_i;
        REG_SAT_LOW:  cfg_q.sat_low  <= cfg_data_i;
        REG_SAT_HIGH: cfg_q.sat_high <= cfg_data_i;
        REG_VAL_LOW:  cfg_q.val_low  <= cfg_data_i;
        REG_VAL_HIGH: cfg_q.val_high <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stall chain, from the output back to the input
  logic rdy_a, rdy_b, rdy_c, div_ready, div_valid;
  logic a_vld_q, b_vld_q, c_vld_q;

  assign rdy_c         = !c_vld_q || m_axis_tready;
  assign rdy_b         = !b_vld_q || div_ready;
  assign rdy_a         = !a_vld_q || rdy_b;
  assign s_axis_tready = rdy_a;

  // Stage A: max, min, excess green, hue sector term
  chan_t                   px_b, px_g, px_r;
  chan_t                   mx_d, mn_d;
  chan_t                   exg_d;
  sector_e                 sec_d;
  logic signed [DIF_W-1:0] t_d;
  logic signed [EXG_W-1:0] e_raw;

  assign px_b = s_axis_tdata[7:0];
  assign px_g = s_axis_tdata[15:8];
  assign px_r = s_axis_tdata[23:16];

  always_comb begin
    mx_d = px_b;
    if (px_g > mx_d) mx_d = px_g;
    if (px_r > mx_d) mx_d = px_r;
    mn_d = px_b;
    if (px_g < mn_d) mn_d = px_g;
    if (px_r < mn_d) mn_d = px_r;

    e_raw = signed'(EXG_W'({px_g, 1'b0})) - signed'(EXG_W'(px_r)) - signed'(EXG_W'(px_b));
    if (e_raw < 0) begin
      exg_d = '0;
    end else if (e_raw > signed'(EXG_W'(CHAN_MAX))) begin
      exg_d = chan_t'(CHAN_MAX);
    end else begin
      exg_d = e_raw[CHANNEL_BITS-1:0];
    end

    // red wins ties, then green
    if (px_r == mx_d) begin
      sec_d = SEC_RED;
      t_d   = signed'(DIF_W'(px_g)) - signed'(DIF_W'(px_b));
    end else if (px_g == mx_d) begin
      sec_d = SEC_GREEN;
      t_d   = signed'(DIF_W'(px_b)) - signed'(DIF_W'(px_r));
    end else begin
      sec_d = SEC_BLUE;
      t_d   = signed'(DIF_W'(px_r)) - signed'(DIF_W'(px_g));
    end
  end

  chan_t                   a_mx_q, a_diff_q, a_exg_q;
  sector_e                 a_sec_q;
  logic signed [DIF_W-1:0] a_t_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (rdy_a) begin
      a_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && s_axis_tvalid) begin
      a_mx_q   <= mx_d;
      a_diff_q <= mx_d - mn_d;
      a_exg_q  <= exg_d;
      a_sec_q  <= sec_d;
      a_t_q    <= t_d;
    end
  end

  // Stage B: divider operands for hue and saturation
  logic signed [HNUM_W-1:0] h_term, h_off, h_num;
  div_st_t                  div_d, b_q, div_out;

  always_comb begin
    h_term = HNUM_W'(a_t_q) * signed'(HNUM_W'(HUE_SIXTH));
    unique case (a_sec_q)
      SEC_RED:   h_off = '0;
      SEC_GREEN: h_off = signed'(HNUM_W'(a_diff_q) * HNUM_W'(2 * HUE_SIXTH));
      SEC_BLUE:  h_off = signed'(HNUM_W'(a_diff_q) * HNUM_W'(4 * HUE_SIXTH));
      default:   h_off = '0;
    endcase
    h_num = h_term + h_off;
    if (h_num < 0) begin
      h_num = h_num + signed'(HNUM_W'(a_diff_q) * HNUM_W'(HUE_HALF));
    end

    // hue = (2*num + diff) / (2*diff), saturation = (510*diff + max) / (2*max)
    div_d.hue.rem  = {h_num[NUM_W-2:0], 1'b0} + NUM_W'(a_diff_q);
    div_d.hue.den  = {a_diff_q, 1'b0};
    div_d.hue.quo  = '0;
    div_d.sat.rem  = NUM_W'(a_diff_q) * NUM_W'(2 * CHAN_MAX) + NUM_W'(a_mx_q);
    div_d.sat.den  = {a_mx_q, 1'b0};
    div_d.sat.quo  = '0;
    div_d.side.exg  = a_exg_q;
    div_d.side.mx   = a_mx_q;
    div_d.side.grey = (a_diff_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (rdy_b) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_b && a_vld_q) begin
      b_q <= div_d;
    end
  end

  // Divider pipeline
  gpm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (b_vld_q),
    .ready_o (div_ready),
    .data_i  (b_q),
    .valid_o (div_valid),
    .ready_i (rdy_c),
    .data_o  (div_out)
  );

  // Stage C: hue wrap, grey override, range tests
  chan_t hue_d, sat_d;
  logic  plant_d;

  always_comb begin
    if (div_out.side.grey || div_out.hue.quo >= Q_W'(HUE_HALF)) begin
      hue_d = '0;
    end else begin
      hue_d = div_out.hue.quo;
    end
    sat_d = div_out.side.grey ? '0 : div_out.sat.quo;

    plant_d = (div_out.side.exg >= cfg_q.exg_low) && (div_out.side.exg <= cfg_q.exg_high) &&
              (hue_d >= cfg_q.hue_low) && (hue_d <= cfg_q.hue_high) &&
              (sat_d >= cfg_q.sat_low) && (sat_d <= cfg_q.sat_high) &&
              (div_out.side.mx >= cfg_q.val_low) && (div_out.side.mx <= cfg_q.val_high);
  end

  logic  c_plant_q;
  chan_t c_exg_q, c_hue_q, c_sat_q, c_val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (rdy_c) begin
      c_vld_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_c && div_valid) begin
      c_plant_q <= plant_d;
      c_exg_q   <= div_out.side.exg;
      c_hue_q   <= hue_d;
      c_sat_q   <= sat_d;
      c_val_q   <= div_out.side.mx;
    end
  end

  assign m_axis_tvalid = c_vld_q;
  assign m_axis_tdata  = {7'b0, c_val_q, c_sat_q, c_hue_q, c_exg_q, c_plant_q};

endmodule

/* src/gpm_div.sv */
// Pipelined restoring divider, two lanes in lockstep, one quotient bit per stage.
`timescale 1ns / 1ps

module gpm_div
  import gpm_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  output logic    ready_o,
  input  div_st_t data_i,
  output logic    valid_o,
  input  logic    ready_i,
  output div_st_t data_o
);

  // One step: subtract the shifted divisor if it fits, set that quotient bit.
  function automatic div_lane_t div_step(div_lane_t l, logic [QI_W-1:0] sh);
    logic [NUM_W-1:0] dsh;
    div_lane_t        o;
    begin
      o   = l;
      dsh = NUM_W'(l.den) << sh;
      if (l.rem >= dsh) begin
        o.rem     = l.rem - dsh;
        o.quo[sh] = 1'b1;
      end
      return o;
    end
  endfunction

  div_st_t st_q   [DIV_STAGES];
  logic    vld_q  [DIV_STAGES];
  logic    rdy    [DIV_STAGES];

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
    localparam logic [QI_W-1:0] SH = QI_W'(DIV_STAGES - 1 - i);

    div_st_t src;
    logic    src_vld;
    div_st_t nxt;

    if (i == 0) begin : g_first
      assign src     = data_i;
      assign src_vld = valid_i;
    end else begin : g_mid
      assign src     = st_q[i-1];
      assign src_vld = vld_q[i-1];
    end

    // Stage takes a beat when empty or when its successor moves.
    if (i == DIV_STAGES - 1) begin : g_last
      assign rdy[i] = !vld_q[i] || ready_i;
    end else begin : g_inner
      assign rdy[i] = !vld_q[i] || rdy[i+1];
    end

    always_comb begin
      nxt     = src;
      nxt.sat = div_step(src.sat, SH);
      nxt.hue = div_step(src.hue, SH);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (rdy[i]) begin
        vld_q[i] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[i] && src_vld) begin
        st_q[i] <= nxt;
      end
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = vld_q[DIV_STAGES-1];
  assign data_o  = st_q[DIV_STAGES-1];

endmodule

/* src/gpm_checker.sv */
// Port-level checker for the green pixel classifier, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gpm_checker
  import gpm_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  chan_t o_exg, o_hue, o_sat, o_val;

  assign o_exg = m_axis_tdata[8:1];
  assign o_hue = m_axis_tdata[16:9];
  assign o_sat = m_axis_tdata[24:17];
  assign o_val = m_axis_tdata[32:25];

  // stalled result beat holds
  `GPM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result beat changed while stalled")

  // hue wraps at a half turn
  `GPM_ASSERT(a_hue_range, m_axis_tvalid |-> (o_hue < chan_t'(HUE_HALF)), "hue above 179")

  // zero saturation means a grey pixel, which has zero hue
  `GPM_ASSERT(a_grey_hue, m_axis_tvalid && (o_sat == '0) |-> (o_hue == '0), "grey pixel with nonzero hue")

  // black pixel: all channels zero
  `GPM_ASSERT(a_black, m_axis_tvalid && (o_val == '0) |-> (o_sat == '0) && (o_exg == '0), "black pixel with nonzero saturation or excess green")

endmodule

bind green_pixel_mask_classifier_top gpm_checker u_gpm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
